FILE: hdl/wao_pkg.sv
`timescale 1ns / 1ps
// Package for the window average outlier monitor.
// Holds shared widths, register indexes, the item control struct and the back-end state type.
package wao_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_WINDOW  = 64;
    localparam int DEF_SAMPLE_BITS = 32;

    // Fixed field and register widths.
    localparam int IN_W       = 32;
    localparam int AVG_W      = 32;
    localparam int WS_W       = 7;
    localparam int THR_W      = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXTRA_THRESHOLD = 1'd1;

    // Reset values of the configuration registers.
    localparam logic [WS_W-1:0]  WS_RESET  = 7'd16;
    localparam logic [THR_W-1:0] THR_RESET = 32'd0;

    // Classification the front end attaches to every word.
    typedef struct packed {
        logic was_full;    // window already full before this sample
        logic full_after;  // window full once this sample is stored
        logic period_end;  // sample count reaches a multiple of the window
    } t_item_ctl;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_DIV,
        ST_BOUNDS,
        ST_FLAG,
        ST_DONE
    } t_back_state;

endpackage

FILE: hdl/wao_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package dependency.
module wao_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/wao_queue.sv
`timescale 1ns / 1ps
// Two-entry word queue between the front end and the back end.
// Stand-alone; no package dependency.
module wao_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_full,
    output logic [WIDTH-1:0] o_data
);

    localparam int DEPTH = 2;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_count;

    // Storage is written without reset; only counted entries are read.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'(DEPTH));
    assign o_data  = r_mem[r_rd];

endmodule

FILE: hdl/wao_front.sv
`timescale 1ns / 1ps
// Front end: accepts sample words, tracks fill level, ring pointer and period phase,
// and classifies each word for the back end. Depends on wao_pkg.
module wao_front #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 32,
    parameter int WIN_W       = $clog2(MAX_WINDOW + 1),
    parameter int PTR_W       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_restart,
    input  logic [WIN_W-1:0]       i_win,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [wao_pkg::IN_W-1:0] i_sample,
    input  logic                   i_q_full,
    output logic                   o_push,
    output wao_pkg::t_item_ctl     o_ctl,
    output logic [SAMPLE_BITS-1:0] o_sample,
    output logic [PTR_W-1:0]       o_wp,
    output logic [PTR_W-1:0]       o_old_idx
);

    import wao_pkg::*;

    logic [WIN_W-1:0] r_fill;
    logic [WIN_W-1:0] r_phase;
    logic [PTR_W-1:0] r_wp;

    logic [WIN_W-1:0] n_fill;
    logic [WIN_W-1:0] n_phase;
    logic [PTR_W-1:0] n_wp;
    logic [WIN_W:0]   phase_inc;
    logic [WIN_W:0]   old_sum;
    logic [WIN_W:0]   old_wrap;
    logic             accept;
    t_item_ctl        ctl;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign o_push  = accept;

    // Classify the word against the current counters.
    always_comb begin
        ctl.was_full = (r_fill >= i_win);
        if (ctl.was_full) begin
            n_fill = i_win;
        end else begin
            n_fill = r_fill + WIN_W'(1);
        end
        ctl.full_after = (n_fill >= i_win);

        phase_inc = {1'b0, r_phase} + (WIN_W + 1)'(1);
        ctl.period_end = (phase_inc >= {1'b0, i_win});
        if (ctl.period_end) begin
            n_phase = '0;
        end else begin
            n_phase = phase_inc[WIN_W-1:0];
        end

        if (r_wp == PTR_W'(MAX_WINDOW - 1)) begin
            n_wp = '0;
        end else begin
            n_wp = r_wp + PTR_W'(1);
        end
    end

    // Ring slot of the oldest sample: wp minus the window, modulo the ring depth.
    always_comb begin
        old_sum = (WIN_W + 1)'(r_wp) + (WIN_W + 1)'(MAX_WINDOW) - {1'b0, i_win};
        if (old_sum >= (WIN_W + 1)'(MAX_WINDOW)) begin
            old_wrap = old_sum - (WIN_W + 1)'(MAX_WINDOW);
        end else begin
            old_wrap = old_sum;
        end
    end

    assign o_ctl     = ctl;
    assign o_sample  = i_sample[SAMPLE_BITS-1:0];
    assign o_wp      = r_wp;
    assign o_old_idx = old_wrap[PTR_W-1:0];

    // Counter registers; a window size write restarts them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_fill  <= '0;
            r_phase <= '0;
            r_wp    <= '0;
        end else if (accept) begin
            r_fill  <= n_fill;
            r_phase <= n_phase;
            r_wp    <= n_wp;
        end
    end

endmodule

FILE: hdl/wao_back.sv
`timescale 1ns / 1ps
// Back end: updates the sample ring and running sum, divides by the window one bit
// per cycle, checks the outlier bounds and holds the result word. Depends on wao_pkg, wao_ram.
module wao_back #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 32,
    parameter int WIN_W       = $clog2(MAX_WINDOW + 1),
    parameter int PTR_W       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_restart,
    input  logic [WIN_W-1:0]          i_win,
    input  logic [wao_pkg::THR_W-1:0] i_threshold,
    input  logic                      i_q_valid,
    input  wao_pkg::t_item_ctl        i_ctl,
    input  logic [SAMPLE_BITS-1:0]    i_sample,
    input  logic [PTR_W-1:0]          i_wp,
    input  logic [PTR_W-1:0]          i_old_idx,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_window_full,
    output logic [wao_pkg::AVG_W-1:0] o_average,
    output logic                      o_outlier,
    output logic                      o_period_end
);

    import wao_pkg::*;

    localparam int SUM_W = SAMPLE_BITS + WIN_W;
    localparam int CNT_W = $clog2(SUM_W + 1);

    t_back_state r_state;
    t_back_state n_state;

    // Current word.
    t_item_ctl              r_ctl;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [PTR_W-1:0]       r_wp;
    logic [PTR_W-1:0]       r_old_idx;

    // Statistics.
    logic [SUM_W-1:0]       r_sum;
    logic [SUM_W-1:0]       n_sum;
    logic [SAMPLE_BITS-1:0] r_held;

    // Divider.
    logic [WIN_W-1:0]       r_rem;
    logic [SUM_W-1:0]       r_quo;
    logic [CNT_W-1:0]       r_cnt;
    logic [WIN_W:0]         rem_shift;
    logic                   quo_bit;
    logic                   div_last;

    // Bounds check.
    logic [SAMPLE_BITS-1:0] avg;
    logic [SAMPLE_BITS+1:0] avg_x3;
    logic [SAMPLE_BITS:0]   upper;
    logic [SAMPLE_BITS-1:0] lower;
    logic                   r_above;
    logic                   r_below;
    logic [SAMPLE_BITS-1:0] r_delta;
    logic                   r_flag;

    // Output register.
    logic                   r_out_valid;
    logic                   r_out_full;
    logic [AVG_W-1:0]       r_out_avg;
    logic                   r_out_flag;
    logic                   r_out_pend;

    // Strobes.
    logic                   ram_we;
    logic                   load_out;
    logic [SAMPLE_BITS-1:0] old_sample;

    wao_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW),
        .AW    (PTR_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (r_sample),
        .i_raddr (r_old_idx),
        .o_rdata (old_sample)
    );

    // Divider step: shift in the next dividend bit, subtract the window if it fits.
    always_comb begin
        rem_shift = {r_rem, r_quo[SUM_W-1]};
        quo_bit   = (rem_shift >= {1'b0, i_win});
        div_last  = (r_cnt == CNT_W'(SUM_W - 1));
    end

    // Sum after dropping the oldest sample.
    always_comb begin
        if (r_ctl.was_full) begin
            n_sum = r_sum - SUM_W'(old_sample);
        end else begin
            n_sum = r_sum;
        end
    end

    // Outlier bounds: 3/2 of the average above, half of it below.
    always_comb begin
        avg    = r_quo[SAMPLE_BITS-1:0];
        avg_x3 = {avg, 1'b0} + (SAMPLE_BITS + 2)'(avg);
        upper  = avg_x3[SAMPLE_BITS+1:1];
        lower  = avg >> 1;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = ST_READ;
                end
            end
            ST_READ:   n_state = ST_SUM;
            ST_SUM: begin
                if (r_ctl.full_after) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DIV: begin
                if (div_last) begin
                    n_state = ST_BOUNDS;
                end
            end
            ST_BOUNDS: n_state = ST_FLAG;
            ST_FLAG:   n_state = ST_DONE;
            ST_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // Control strobes.
    always_comb begin
        o_pop    = 1'b0;
        ram_we   = 1'b0;
        load_out = 1'b0;
        case (r_state)
            ST_IDLE: o_pop    = i_q_valid;
            ST_SUM:  ram_we   = 1'b1;
            ST_DONE: load_out = !r_out_valid || !i_stall;
            default: begin
                o_pop    = 1'b0;
                ram_we   = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    // State register and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Running sum and held average; cleared by reset and by a window size write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_sum  <= '0;
            r_held <= '0;
        end else begin
            if (r_state == ST_READ) begin
                r_sum <= r_sum + SUM_W'(r_sample);
            end else if (r_state == ST_SUM) begin
                r_sum <= n_sum;
            end
            if (r_state == ST_BOUNDS) begin
                r_held <= avg;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ctl     <= i_ctl;
            r_sample  <= i_sample;
            r_wp      <= i_wp;
            r_old_idx <= i_old_idx;
        end
        if (r_state == ST_SUM) begin
            r_rem  <= '0;
            r_quo  <= n_sum;
            r_cnt  <= '0;
            r_flag <= 1'b0;
        end else if (r_state == ST_DIV) begin
            if (quo_bit) begin
                r_rem <= WIN_W'(rem_shift - {1'b0, i_win});
            end else begin
                r_rem <= rem_shift[WIN_W-1:0];
            end
            r_quo <= {r_quo[SUM_W-2:0], quo_bit};
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (r_state == ST_BOUNDS) begin
            r_above <= ({1'b0, r_sample} > upper);
            r_below <= (r_sample < lower);
            if (r_sample > avg) begin
                r_delta <= r_sample - avg;
            end else begin
                r_delta <= avg - r_sample;
            end
        end
        if (r_state == ST_FLAG) begin
            r_flag <= (r_above || r_below)
                      && !((i_threshold != '0) && (THR_W'(r_delta) < i_threshold));
        end
        if (load_out) begin
            r_out_full <= r_ctl.full_after;
            r_out_avg  <= AVG_W'(r_held);
            r_out_flag <= r_flag;
            r_out_pend <= r_ctl.period_end;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_window_full = r_out_full;
    assign o_average     = r_out_avg;
    assign o_outlier     = r_out_flag;
    assign o_period_end  = r_out_pend;

endmodule

FILE: hdl/window_average_outlier_monitor.sv
`timescale 1ns / 1ps
// Window average outlier monitor, top level. Depends on wao_pkg, wao_front, wao_queue, wao_back.
// The back end takes one word at a time and uses a bit-serial divider once the window is
// full (dividend width SUM_W = SAMPLE_BITS + clog2(MAX_WINDOW + 1), 39 by default);
// a two-word queue takes words while the back end is busy.
// Reset (synchronous, active low) clears counters, sum, held average and handshakes;
// window_size returns to 16, extra_threshold to 0. Ring contents are not cleared.
module window_average_outlier_monitor #(
    parameter int MAX_WINDOW  = wao_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = wao_pkg::DEF_SAMPLE_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [wao_pkg::IN_W-1:0]       i_sample,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_window_full,
    output logic [wao_pkg::AVG_W-1:0]      o_average,
    output logic                           o_outlier,
    output logic                           o_period_end,
    input  logic                           i_cfg_we,
    input  logic [wao_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wao_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import wao_pkg::*;

    localparam int WIN_W = $clog2(MAX_WINDOW + 1);
    localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CTL_W = $bits(t_item_ctl);
    localparam int Q_W   = CTL_W + SAMPLE_BITS + 2 * PTR_W;

    logic [WS_W-1:0]  r_window_size;
    logic [THR_W-1:0] r_threshold;
    logic             restart;
    logic [WIN_W-1:0] win;

    logic                   push;
    logic                   pop;
    logic                   q_valid;
    logic                   q_full;
    t_item_ctl              f_ctl;
    logic [SAMPLE_BITS-1:0] f_sample;
    logic [PTR_W-1:0]       f_wp;
    logic [PTR_W-1:0]       f_old_idx;
    logic [Q_W-1:0]         q_in;
    logic [Q_W-1:0]         q_out;
    t_item_ctl              b_ctl;
    logic [SAMPLE_BITS-1:0] b_sample;
    logic [PTR_W-1:0]       b_wp;
    logic [PTR_W-1:0]       b_old_idx;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= WS_RESET;
            r_threshold   <= THR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WINDOW_SIZE:     r_window_size <= i_cfg_data[WS_W-1:0];
                REG_EXTRA_THRESHOLD: r_threshold   <= i_cfg_data[THR_W-1:0];
                default:             r_threshold   <= r_threshold;
            endcase
        end
    end

    // A window size write restarts the statistics.
    assign restart = i_cfg_we && (i_cfg_idx == REG_WINDOW_SIZE);

    // Effective window: zero reads as one, large values saturate to the ring depth.
    always_comb begin
        if (r_window_size == '0) begin
            win = WIN_W'(1);
        end else if (int'(r_window_size) > MAX_WINDOW) begin
            win = WIN_W'(MAX_WINDOW);
        end else begin
            win = WIN_W'(r_window_size);
        end
    end

    wao_front #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .WIN_W       (WIN_W),
        .PTR_W       (PTR_W)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_win     (win),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_sample  (i_sample),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_ctl     (f_ctl),
        .o_sample  (f_sample),
        .o_wp      (f_wp),
        .o_old_idx (f_old_idx)
    );

    // Queue word layout: control, sample, write slot, oldest slot.
    assign q_in = {f_ctl, f_sample, f_wp, f_old_idx};
    assign {b_ctl, b_sample, b_wp, b_old_idx} = q_out;

    wao_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (q_out)
    );

    wao_back #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .WIN_W       (WIN_W),
        .PTR_W       (PTR_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_restart     (restart),
        .i_win         (win),
        .i_threshold   (r_threshold),
        .i_q_valid     (q_valid),
        .i_ctl         (b_ctl),
        .i_sample      (b_sample),
        .i_wp          (b_wp),
        .i_old_idx     (b_old_idx),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_window_full (o_window_full),
        .o_average     (o_average),
        .o_outlier     (o_outlier),
        .o_period_end  (o_period_end)
    );

endmodule
